// ===== hdl/ppte_pkg.sv =====
// ============================================================================
// ppte_pkg
// Shared types, register indexes and constants of the pulse position
// telemetry encoder.
// ============================================================================
package ppte_pkg;

    // Segment code buffer
    localparam int BUF_DEPTH = 32;
    localparam int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int IDX_W     = ($clog2(BUF_DEPTH + 1) > 5) ? $clog2(BUF_DEPTH + 1) : 5;
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(BUF_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PRESCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PULSES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STEPS    = 3'd4;

    localparam logic [15:0] RST_STEP_PRESCALE = 16'h007d;
    localparam logic [3:0]  RST_SYNC_PULSES   = 4'd3;
    localparam logic [9:0]  RST_PULSE_PERIOD  = 10'd96;
    localparam logic [9:0]  RST_PULSE_WIDTH   = 10'd48;
    localparam logic [7:0]  RST_SLOT_STEPS    = 8'd24;

    // Item functions
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_LOAD = 2'd1;
    localparam logic [1:0] FUNC_ACK  = 2'd2;

    // Segment code fields
    localparam logic [7:0] CODE_COUNT_MASK = 8'h1f;
    localparam logic [7:0] CODE_COMPL      = 8'h20;
    localparam logic [7:0] CODE_GAP        = 8'h40;
    localparam logic [7:0] CODE_PULSE      = 8'h80;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] slot_index;
        logic [7:0] code_byte;
    } item_t;

    typedef struct packed {
        logic       pulse_out;
        logic       sync_phase;
        logic       done_res;
        logic [5:0] segment_number;
    } result_t;

endpackage

// ===== hdl/pulse_position_telemetry_encoder.sv =====
// ============================================================================
// pulse_position_telemetry_encoder
// Drives a one-bit telemetry pulse line: prescaled steps, a sync pulse train,
// then gap and pulse segments walked from a stored segment code buffer.
// ============================================================================
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+--------------------------------
//  config   | cfg_we, cfg_index, cfg_wdata     | register write, no wait
//  item     | item_valid, item_ready, item     | tick / load code / acknowledge
//  result   | result_valid, result_ready,      | line level, phase, done,
//           | result                           | segment number
//
//  One item per cycle unless results stall; each result is registered on accept.
//  The code buffer is two mirrored RAMs, read every cycle at the current and the
//  next segment, with addresses taken from the next state, so the step of the
//  following item finds its codes ready; a write in the same cycle is forwarded.
//  Reset clears the buffer through per-entry valid bits at once, no clearing pass.
//  A stalled result holds the item side only while the output register is full.
//
module pulse_position_telemetry_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ppte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppte_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ppte_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ppte_pkg::result_t                   result
);

    localparam int AW    = ppte_pkg::AW;
    localparam int IDX_W = ppte_pkg::IDX_W;

    // configuration
    logic [15:0] step_prescale_reg;
    logic [3:0]  sync_pulses_reg;
    logic [9:0]  pulse_period_reg;
    logic [9:0]  pulse_width_reg;
    logic [7:0]  slot_steps_reg;

    // line state
    logic [15:0]      prescale_reg,  prescale_next;
    logic             in_data_reg,   in_data_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;
    logic [15:0]      pos_reg,       pos_next;
    logic [15:0]      seg_len_reg,   seg_len_next;
    logic [15:0]      gap_reg,       gap_next;
    logic             done_reg,      done_next;
    logic             line_reg,      line_next;

    // buffer
    logic [ppte_pkg::BUF_DEPTH-1:0] vld_reg;
    logic [AW-1:0]    ra_a_reg, ra_a_next;
    logic [AW-1:0]    ra_b_reg, ra_b_next;
    logic             fwd_a_reg, fwd_a_next;
    logic             fwd_b_reg, fwd_b_next;
    logic [7:0]       fwd_data_reg;
    logic [7:0]       ram_a_q, ram_b_q;
    logic [7:0]       code_cur, code_nxt;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW+4:0]    slot_wide;
    logic [IDX_W-1:0] idx_next_inc;

    // handshake
    logic              item_xfer;
    logic              step;
    logic              result_valid_reg;
    ppte_pkg::result_t result_reg, result_next;
    logic [IDX_W+5:0]  seg_wide;

    assign item_ready = !result_valid_reg || result_ready;
    assign item_xfer  = item_valid && item_ready;
    assign step       = item_xfer && (item.func == ppte_pkg::FUNC_TICK) && (prescale_reg == 16'd0);

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_prescale_reg <= ppte_pkg::RST_STEP_PRESCALE;
            sync_pulses_reg   <= ppte_pkg::RST_SYNC_PULSES;
            pulse_period_reg  <= ppte_pkg::RST_PULSE_PERIOD;
            pulse_width_reg   <= ppte_pkg::RST_PULSE_WIDTH;
            slot_steps_reg    <= ppte_pkg::RST_SLOT_STEPS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppte_pkg::CFG_STEP_PRESCALE: step_prescale_reg <= cfg_wdata;
                ppte_pkg::CFG_SYNC_PULSES:   sync_pulses_reg   <= cfg_wdata[3:0];
                ppte_pkg::CFG_PULSE_PERIOD:  pulse_period_reg  <= cfg_wdata[9:0];
                ppte_pkg::CFG_PULSE_WIDTH:   pulse_width_reg   <= cfg_wdata[9:0];
                ppte_pkg::CFG_SLOT_STEPS:    slot_steps_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // code buffer: mirrored RAMs, valid bits, write forwarding
    // ------------------------------------------------------------------
    assign slot_wide = {{AW{1'b0}}, item.slot_index};
    assign wr_addr   = slot_wide[AW-1:0];
    assign wr_en     = item_xfer && (item.func == ppte_pkg::FUNC_LOAD)
                       && (slot_wide < (AW + 5)'(ppte_pkg::BUF_DEPTH));

    assign idx_next_inc = idx_next + IDX_W'(1);
    assign ra_a_next    = idx_next[AW-1:0];
    // next segment in data phase, entry zero while sync runs
    assign ra_b_next    = in_data_next ? idx_next_inc[AW-1:0] : '0;
    assign fwd_a_next   = wr_en && (wr_addr == ra_a_next);
    assign fwd_b_next   = wr_en && (wr_addr == ra_b_next);

    ppte_ram #(
        .WIDTH (8),
        .DEPTH (ppte_pkg::BUF_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (item.code_byte),
        .raddr (ra_a_next),
        .rdata (ram_a_q)
    );

    ppte_ram #(
        .WIDTH (8),
        .DEPTH (ppte_pkg::BUF_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (item.code_byte),
        .raddr (ra_b_next),
        .rdata (ram_b_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            ra_a_reg  <= '0;
            ra_b_reg  <= '0;
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            ra_a_reg  <= ra_a_next;
            ra_b_reg  <= ra_b_next;
            fwd_a_reg <= fwd_a_next;
            fwd_b_reg <= fwd_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= item.code_byte;
    end

    assign code_cur = fwd_a_reg ? fwd_data_reg : (vld_reg[ra_a_reg] ? ram_a_q : 8'h00);
    assign code_nxt = fwd_b_reg ? fwd_data_reg : (vld_reg[ra_b_reg] ? ram_b_q : 8'h00);

    // ------------------------------------------------------------------
    // step logic
    // ------------------------------------------------------------------
    always_comb
    begin
        logic       load;
        logic [5:0] n;
        logic [13:0] prod;
        logic [7:0] c;

        prescale_next = prescale_reg;
        in_data_next  = in_data_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        seg_len_next  = seg_len_reg;
        gap_next      = gap_reg;
        done_next     = done_reg;
        line_next     = line_reg;
        load          = 1'b0;
        n             = 6'd0;
        prod          = 14'd0;
        c             = code_cur;

        if (item_xfer && (item.func == ppte_pkg::FUNC_ACK))
        begin
            done_next = 1'b0;
        end

        if (item_xfer && (item.func == ppte_pkg::FUNC_TICK) && !step)
        begin
            prescale_next = prescale_reg - 16'd1;
        end

        if (step)
        begin
            prescale_next = (step_prescale_reg != 16'd0) ? step_prescale_reg - 16'd1 : 16'd0;

            if (!in_data_reg)
            begin
                if (pos_reg >= {6'd0, pulse_period_reg})
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    pos_next = 16'd0;
                end
                if (idx_next < {{(IDX_W-4){1'b0}}, sync_pulses_reg})
                begin
                    line_next = pos_next < {6'd0, pulse_width_reg};
                end
                else
                begin
                    in_data_next = 1'b1;
                    idx_next     = '0;
                    pos_next     = 16'd0;
                    load         = 1'b1;
                end
            end
            else if (pos_reg >= seg_len_reg)
            begin
                idx_next = idx_reg + IDX_W'(1);
                pos_next = 16'd0;
                load     = 1'b1;
            end

            if (load)
            begin
                if ((idx_next >= ppte_pkg::DEPTH_IDX) || (code_nxt == 8'h00))
                begin
                    // terminator: flag done, back to sync
                    done_next    = 1'b1;
                    in_data_next = 1'b0;
                    idx_next     = '0;
                    pos_next     = 16'd0;
                end
                else
                begin
                    c = code_nxt;
                    if ((code_nxt & ppte_pkg::CODE_GAP) != 8'h00)
                    begin
                        n = {1'b0, code_nxt[4:0] & ppte_pkg::CODE_COUNT_MASK[4:0]};
                        if ((code_nxt & ppte_pkg::CODE_COMPL) != 8'h00)
                        begin
                            n = 6'd32 - n;
                        end
                        prod = {8'd0, n} * {6'd0, slot_steps_reg};
                    end
                    gap_next     = {2'b00, prod};
                    seg_len_next = {2'b00, prod};
                    if ((code_nxt & ppte_pkg::CODE_PULSE) != 8'h00)
                    begin
                        seg_len_next = {2'b00, prod} + {6'd0, pulse_period_reg};
                    end
                end
            end

            // the step that leaves sync keeps the line where sync left it
            if (in_data_reg && in_data_next && !done_next
                && ((c & ppte_pkg::CODE_PULSE) != 8'h00))
            begin
                line_next = (pos_next >= gap_next)
                            && ({1'b0, pos_next} < ({1'b0, gap_next} + {7'd0, pulse_width_reg}));
            end

            pos_next = pos_next + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 16'd0;
            in_data_reg  <= 1'b0;
            idx_reg      <= '0;
            pos_reg      <= 16'd0;
            seg_len_reg  <= 16'd0;
            gap_reg      <= 16'd0;
            done_reg     <= 1'b0;
            line_reg     <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            in_data_reg  <= in_data_next;
            idx_reg      <= idx_next;
            pos_reg      <= pos_next;
            seg_len_reg  <= seg_len_next;
            gap_reg      <= gap_next;
            done_reg     <= done_next;
            line_reg     <= line_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign seg_wide = {6'd0, idx_next};

    always_comb
    begin
        result_next.pulse_out      = line_next;
        result_next.sync_phase     = !in_data_next;
        result_next.done_res       = done_next;
        result_next.segment_number = seg_wide[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_xfer)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_data_idx_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        in_data_reg |-> (idx_reg < ppte_pkg::DEPTH_IDX))
        else $error("segment index past buffer end in data phase");

    a_ack_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item.func == ppte_pkg::FUNC_ACK)) |=> !done_reg)
        else $error("acknowledge did not clear done");

    a_prescale_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item.func == ppte_pkg::FUNC_TICK) && (prescale_reg != 16'd0))
        |=> (prescale_reg == $past(prescale_reg) - 16'd1))
        else $error("prescaler did not count down");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> result_valid)
        else $error("accepted item left no result");

    a_load_writes_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(wr_addr)])
        else $error("written entry not marked valid");
`endif

endmodule

// ===== hdl/ppte_ram.sv =====
// ============================================================================
// ppte_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ppte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== dv/pulse_position_telemetry_encoder_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pulse_position_telemetry_encoder_tb
// Drives ticks, code loads, acknowledges and unused items into the encoder under random
// idling on both channels. It tracks the line level, phase, done flag and
// segment number of every transfer, and compares each result field by field.
// ============================================================================

import ppte_pkg::*;

class pulse_line_scoreboard;

    // Register copies
    bit [15:0] step_prescale;
    bit [3:0]  sync_pulses;
    bit [9:0]  pulse_period;
    bit [9:0]  pulse_width;
    bit [7:0]  slot_steps;

    // Encoder state
    bit [15:0] prescale_cnt;
    bit        data_phase;
    bit [5:0]  seg_idx;
    bit [15:0] step_pos;
    bit [15:0] seg_len;
    bit [15:0] gap_len;
    bit        done;
    bit        level;
    bit [7:0]  codes [BUF_DEPTH];

    result_t expected_states [$];
    int      checked;
    int      mismatches;

    function void reset_state();
        step_prescale = RST_STEP_PRESCALE;
        sync_pulses   = RST_SYNC_PULSES;
        pulse_period  = RST_PULSE_PERIOD;
        pulse_width   = RST_PULSE_WIDTH;
        slot_steps    = RST_SLOT_STEPS;
        prescale_cnt  = '0;
        data_phase    = 1'b0;
        seg_idx       = '0;
        step_pos      = '0;
        seg_len       = '0;
        gap_len       = '0;
        done          = 1'b0;
        level         = 1'b0;
        foreach (codes[i]) codes[i] = 8'h00;
        expected_states.delete();
        checked    = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_STEP_PRESCALE: step_prescale = val;
            CFG_SYNC_PULSES:   sync_pulses   = val[3:0];
            CFG_PULSE_PERIOD:  pulse_period  = val[9:0];
            CFG_PULSE_WIDTH:   pulse_width   = val[9:0];
            CFG_SLOT_STEPS:    slot_steps    = val[7:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_states.size();
    endfunction

    function bit [7:0] code_at(bit [5:0] idx);
        if (int'(idx) < BUF_DEPTH)
            return codes[idx[AW-1:0]];
        return 8'h00;
    endfunction

    function void end_message();
        done       = 1'b1;
        data_phase = 1'b0;
        seg_idx    = '0;
        step_pos   = '0;
    endfunction

    // Zero code or buffer end terminates the message
    function void load_segment();
        bit [7:0]    c;
        int unsigned n;
        c = code_at(seg_idx);
        if (c == 8'h00) begin
            end_message();
            return;
        end
        gap_len = '0;
        if ((c & CODE_GAP) != 0) begin
            n = 32'(c & CODE_COUNT_MASK);
            if ((c & CODE_COMPL) != 0)
                n = int'(CODE_COMPL) - n;
            gap_len = 16'(n * slot_steps);
        end
        seg_len = gap_len;
        if ((c & CODE_PULSE) != 0)
            seg_len = seg_len + 16'(pulse_period);
    endfunction

    function void step_line();
        bit [7:0] c;
        if (!data_phase) begin
            if (step_pos >= 16'(pulse_period)) begin
                seg_idx  = seg_idx + 6'd1;
                step_pos = '0;
            end
            if (seg_idx < 6'(sync_pulses)) begin
                level = (step_pos < 16'(pulse_width));
            end
            else begin
                data_phase = 1'b1;
                seg_idx    = '0;
                step_pos   = '0;
                load_segment();
            end
        end
        else begin
            if (step_pos >= seg_len) begin
                seg_idx  = seg_idx + 6'd1;
                step_pos = '0;
                load_segment();
            end
            // Done holds the line where it is
            if (data_phase && !done) begin
                c = code_at(seg_idx);
                if ((c & CODE_PULSE) != 0)
                    level = (step_pos >= gap_len) &&
                            (int'(step_pos) < int'(gap_len) + int'(pulse_width));
            end
        end
        step_pos = step_pos + 16'd1;
    endfunction

    function void record_item(item_t it);
        result_t r;
        case (it.func)
            FUNC_TICK: begin
                if (prescale_cnt == 16'd0) begin
                    prescale_cnt = (step_prescale != 16'd0) ? step_prescale - 16'd1 : 16'd0;
                    step_line();
                end
                else begin
                    prescale_cnt = prescale_cnt - 16'd1;
                end
            end
            FUNC_LOAD: begin
                if (int'(it.slot_index) < BUF_DEPTH)
                    codes[it.slot_index] = it.code_byte;
            end
            FUNC_ACK: done = 1'b0;
            default: ;
        endcase
        r.pulse_out      = level;
        r.sync_phase     = !data_phase;
        r.done_res       = done;
        r.segment_number = seg_idx;
        expected_states.push_back(r);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH: %s", msg);
    endtask

    task check_line_state(result_t got);
        result_t want;
        checked++;
        if (expected_states.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
            return;
        end
        want = expected_states.pop_front();
        if (got.pulse_out !== want.pulse_out)
            report_mismatch($sformatf("result %0d pulse_out got %b want %b",
                                      checked, got.pulse_out, want.pulse_out));
        if (got.sync_phase !== want.sync_phase)
            report_mismatch($sformatf("result %0d sync_phase got %b want %b",
                                      checked, got.sync_phase, want.sync_phase));
        if (got.done_res !== want.done_res)
            report_mismatch($sformatf("result %0d done_res got %b want %b",
                                      checked, got.done_res, want.done_res));
        if (got.segment_number !== want.segment_number)
            report_mismatch($sformatf("result %0d segment_number got %0d want %0d",
                                      checked, got.segment_number, want.segment_number));
    endtask

endclass

module pulse_position_telemetry_encoder_tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         IDLE_PCT    = 22;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;

    pulse_line_scoreboard sb = new;
    int                   accepted_items;

    pulse_position_telemetry_encoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, a quiet stretch, and two long hold-offs
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready === 1'b1) begin
                sb.check_line_state(result);
                if (sb.checked == 150 || sb.checked == 1000)
                    hold_left = 64;
            end
            if (hold_left > 0) begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (sb.checked >= 500 && sb.checked < 750) begin
                result_ready <= 1'b1;
            end
            else begin
                result_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic item_t make_item(logic [1:0] func, logic [4:0] slot, logic [7:0] code);
        item_t it;
        it.func       = func;
        it.slot_index = slot;
        it.code_byte  = code;
        return it;
    endfunction

    function automatic logic [7:0] message_code(bit short_seg);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (short_seg) begin
            c[5]   = 1'b0;
            c[4:0] = 5'($urandom_range(0, 2));
        end
        if (c == 8'h00)
            c = CODE_PULSE;
        return c;
    endfunction

    // Hold valid and payload until the transfer
    task automatic send_item(input item_t it);
        while ((accepted_items < 500 || accepted_items >= 750) &&
               $urandom_range(99) < IDLE_PCT) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_ready !== 1'b1);
        sb.record_item(it);
        if (it.func != FUNC_UNUSED)
            accepted_items++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        item_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [15:0] prescale, sync, period, width, slots);
        wait_drained();
        write_reg(CFG_STEP_PRESCALE, prescale);
        write_reg(CFG_SYNC_PULSES, sync);
        write_reg(CFG_PULSE_PERIOD, period);
        write_reg(CFG_PULSE_WIDTH, width);
        write_reg(CFG_SLOT_STEPS, slots);
        cfg_we <= 1'b0;
    endtask

    task automatic load_message(input bit fill_all);
        int  len;
        bit  short_seg;
        len       = fill_all ? BUF_DEPTH : $urandom_range(1, 8);
        short_seg = fill_all || ($urandom_range(1) == 0);
        for (int i = 0; i < len; i++)
            send_item(make_item(FUNC_LOAD, 5'(i), message_code(short_seg)));
        if (!fill_all)
            send_item(make_item(FUNC_LOAD, 5'(len), 8'h00));
    endtask

    task automatic run_phase(input logic [15:0] prescale, sync, period, width, slots,
                             input int n_items, input bit fill_all, input bit pause_sender);
        int    start;
        int    next_reload;
        int    r;
        bit    paused;
        item_t it;
        configure(prescale, sync, period, width, slots);
        start       = accepted_items;
        next_reload = 0;
        paused      = 1'b0;
        while (accepted_items - start < n_items) begin
            if (accepted_items - start >= next_reload) begin
                load_message(fill_all);
                next_reload = fill_all ? n_items : next_reload + 120;
            end
            if (pause_sender && !paused && accepted_items - start >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            r  = $urandom_range(99);
            it = make_item(FUNC_TICK, 5'($urandom), 8'($urandom));
            if (sb.done && r < 20)
                it.func = FUNC_ACK;
            else if (r < 2)
                it.func = FUNC_UNUSED;
            else if (r < 4)
                it.func = FUNC_ACK;
            else if (r < 8 && !fill_all)
                it.func = FUNC_LOAD;
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        item_valid     <= 1'b0;
        item           <= '0;
        accepted_items = 0;
        sb.reset_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: code corners, unused func, ack while idle, a short run of ticks
        configure(16'd1, 16'd1, 16'd2, 16'd1, 16'd1);
        send_item(make_item(FUNC_ACK, 5'd0, 8'h00));
        send_item(make_item(FUNC_UNUSED, 5'd31, 8'hFF));
        send_item(make_item(FUNC_LOAD, 5'd0, 8'hFF));
        send_item(make_item(FUNC_LOAD, 5'd1, 8'h80));
        send_item(make_item(FUNC_LOAD, 5'd2, 8'h40));
        send_item(make_item(FUNC_LOAD, 5'd3, 8'h41));
        send_item(make_item(FUNC_LOAD, 5'd4, 8'h60));
        send_item(make_item(FUNC_LOAD, 5'd5, 8'h00));
        send_item(make_item(FUNC_LOAD, 5'd31, 8'hFF));
        repeat (14) send_item(make_item(FUNC_TICK, 5'd31, 8'hFF));
        send_item(make_item(FUNC_ACK, 5'd31, 8'hFF));

        // Random phases; upper register bits are dropped by the block
        run_phase(16'd1, 16'hFFF2, 16'hFC03, 16'h0402, 16'h0101, 280, 1'b0, 1'b0);
        run_phase(16'd0, 16'd0, 16'd4, 16'd5, 16'd2, 250, 1'b0, 1'b1);
        run_phase(16'd2, 16'd15, 16'd1, 16'd1, 16'd0, 180, 1'b0, 1'b0);
        run_phase(16'd1, 16'd4, 16'd0, 16'd0, 16'd3, 160, 1'b0, 1'b0);
        run_phase(16'd0, 16'd2, 16'd3, 16'd2, 16'd1, 400, 1'b1, 1'b0);
        run_phase(16'd1, 16'd3, 16'd1023, 16'd1023, 16'd255, 80, 1'b0, 1'b0);
        run_phase(16'd65535, 16'd1, 16'd2, 16'd1, 16'd1, 80, 1'b0, 1'b0);

        wait_drained();
        repeat (16) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
